@@ rtl/byte_ring_buffer_with_random_removal_core_assert.svh @@
// assertion macros shared by the byte ring buffer modules
// depends on signals named clk and rst in the including module
`ifndef BYTE_RING_BUFFER_WITH_RANDOM_REMOVAL_CORE_ASSERT_SVH
`define BYTE_RING_BUFFER_WITH_RANDOM_REMOVAL_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BRRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define BRRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BRRB_ASSERT_NOW(lbl, ante, cons, msg)
`define BRRB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/brrb_pkg.sv @@
// types, codes and constants of the byte ring buffer
// no dependencies
`default_nettype none
package brrb_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int POS_W = 7;
  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] CAP_RESET = 8'd128;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH = 2'd0,
    KIND_PEEK = 2'd1,
    KIND_POLL = 2'd2,
    KIND_FWD  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic cfg_we;
    logic load;
    logic do_push;
    logic do_fwd;
    logic set_err;
    logic capture;
    logic pop_head;
    logic pop_mid;
    logic shift_rd;
    logic shift_wr;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  can_push;
    logic  pos_ok;
    logic  pos_zero;
    logic  pos_more;
    logic  skip_ok;
    logic  shift_more;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/brrb_ram.sv @@
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module brrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/brrb_ctrl.sv @@
// operation sequencer of the byte ring buffer
// depends on brrb_pkg and the assertion macro header
`default_nettype none
`include "byte_ring_buffer_with_random_removal_core_assert.svh"
module brrb_ctrl
  import brrb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic cap_valid,
  input  wire sts_t sts,
  output logic      busy,
  output logic      done,
  output logic      cap_ready,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if ((sts.kind == KIND_PEEK || sts.kind == KIND_POLL) && sts.pos_ok) begin
          state_next = ST_READ_WAIT;
        end else begin
          state_next = ST_REPLY;
        end
      end
      ST_READ_WAIT: begin
        if (sts.kind == KIND_POLL && !sts.pos_zero && sts.pos_more) begin
          state_next = ST_SHIFT_RD;
        end else begin
          state_next = ST_REPLY;
        end
      end
      ST_SHIFT_RD: state_next = ST_SHIFT_WR;
      ST_SHIFT_WR: begin
        if (sts.shift_more) begin
          state_next = ST_SHIFT_RD;
        end else begin
          state_next = ST_REPLY;
        end
      end
      ST_REPLY: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    done      = 1'b0;
    cap_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        busy       = 1'b0;
        cap_ready  = !start;
        cmd.load   = start;
        cmd.cfg_we = cap_valid && !start;
      end
      ST_EXEC: begin
        case (sts.kind)
          KIND_PUSH: begin
            cmd.do_push = sts.can_push;
            cmd.set_err = !sts.can_push;
          end
          KIND_FWD: begin
            cmd.do_fwd  = sts.skip_ok;
            cmd.set_err = !sts.skip_ok;
          end
          default: begin
            cmd.set_err = !sts.pos_ok;
          end
        endcase
      end
      ST_READ_WAIT: begin
        cmd.capture = 1'b1;
        if (sts.kind == KIND_POLL) begin
          cmd.pop_head = sts.pos_zero;
          cmd.pop_mid  = !sts.pos_zero;
        end
      end
      ST_SHIFT_RD: cmd.shift_rd = 1'b1;
      ST_SHIFT_WR: cmd.shift_wr = 1'b1;
      ST_REPLY:    done = 1'b1;
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  `BRRB_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `BRRB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `BRRB_ASSERT_NOW(a_cfg_idle, cmd.cfg_we, !busy && !cmd.load, "config write during an item")

endmodule
`default_nettype wire

@@ rtl/brrb_dp.sv @@
// pointers, counters, operand and result registers of the byte ring buffer
// depends on brrb_pkg, brrb_ram and the assertion macro header
`default_nettype none
`include "byte_ring_buffer_with_random_removal_core_assert.svh"
module brrb_dp
  import brrb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [BYTE_W-1:0] push_byte,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [CNT_W-1:0]  skip_count,
  input  wire logic [CNT_W-1:0]  cap_data,
  output sts_t                   sts,
  output logic                   status,
  output logic      [BYTE_W-1:0] read_byte,
  output logic      [CNT_W-1:0]  fill_count,
  output logic      [CNT_W-1:0]  free_count
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int SumW = CntW + 1;

  function automatic logic [PtrW-1:0] wrap_add(
    input logic [PtrW-1:0] base,
    input logic [CntW-1:0] off,
    input logic [CntW-1:0] lim
  );
    logic [SumW-1:0] s;
    s = SumW'(base) + SumW'(off);
    if (s >= SumW'(lim)) begin
      s = s - SumW'(lim);
    end
    return s[PtrW-1:0];
  endfunction

  logic [CNT_W-1:0]  cap_reg;
  logic [PtrW-1:0]   head;
  logic [PtrW-1:0]   tail;
  logic [CntW-1:0]   count;
  logic [PtrW-1:0]   k;
  kind_t             op_kind;
  logic [BYTE_W-1:0] op_byte;
  logic [POS_W-1:0]  op_pos;
  logic [CNT_W-1:0]  op_skip;
  logic              err;
  logic [BYTE_W-1:0] rbyte;

  logic [CntW-1:0]   cap_eff;
  logic [PtrW-1:0]   idx_pos;
  logic [PtrW-1:0]   idx_k;
  logic [PtrW-1:0]   idx_k1;
  logic              ram_we;
  logic [PtrW-1:0]   ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [PtrW-1:0]   ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  always_comb begin
    if (cap_reg == '0) begin
      cap_eff = CntW'(1);
    end else if (cap_reg > CNT_W'(DEPTH)) begin
      cap_eff = CntW'(DEPTH);
    end else begin
      cap_eff = cap_reg[CntW-1:0];
    end
  end

  assign idx_pos = wrap_add(head, CntW'(op_pos), cap_eff);
  assign idx_k   = wrap_add(head, CntW'(k), cap_eff);
  assign idx_k1  = wrap_add(head, CntW'(k) + CntW'(1), cap_eff);

  assign ram_we    = cmd.do_push || cmd.shift_wr;
  assign ram_waddr = cmd.shift_wr ? idx_k : tail;
  assign ram_wdata = cmd.shift_wr ? ram_rdata : op_byte;
  assign ram_raddr = cmd.shift_rd ? idx_k1 : idx_pos;

  brrb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CAP_RESET;
      head    <= '0;
      tail    <= '0;
      count   <= '0;
    end else if (cmd.cfg_we) begin
      cap_reg <= cap_data;
      head    <= '0;
      tail    <= '0;
      count   <= '0;
    end else begin
      if (cmd.do_push) begin
        tail  <= wrap_add(tail, CntW'(1), cap_eff);
        count <= count + CntW'(1);
      end
      if (cmd.do_fwd) begin
        head  <= wrap_add(head, CntW'(op_skip), cap_eff);
        count <= count - CntW'(op_skip);
      end
      if (cmd.pop_head) begin
        head  <= wrap_add(head, CntW'(1), cap_eff);
        count <= count - CntW'(1);
      end
      if (cmd.pop_mid) begin
        tail  <= (tail == '0) ? PtrW'(cap_eff - CntW'(1)) : tail - PtrW'(1);
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind <= kind_t'(kind);
      op_byte <= push_byte;
      op_pos  <= position;
      op_skip <= skip_count;
      err     <= 1'b0;
      rbyte   <= '0;
    end
    if (cmd.set_err) begin
      err <= 1'b1;
    end
    if (cmd.capture) begin
      rbyte <= ram_rdata;
    end
    if (cmd.pop_mid) begin
      k <= PtrW'(op_pos);
    end else if (cmd.shift_wr) begin
      k <= k + PtrW'(1);
    end
  end

  always_comb begin
    sts.kind       = op_kind;
    sts.can_push   = count < cap_eff;
    sts.pos_ok     = CNT_W'(op_pos) < CNT_W'(count);
    sts.pos_zero   = op_pos == '0;
    sts.pos_more   = (CNT_W'(op_pos) + CNT_W'(1)) < CNT_W'(count);
    sts.skip_ok    = op_skip <= CNT_W'(count);
    sts.shift_more = (SumW'(k) + SumW'(1)) < SumW'(count);
  end

  assign status     = err;
  assign read_byte  = rbyte;
  assign fill_count = CNT_W'(count);
  assign free_count = CNT_W'(cap_eff - count);

  `BRRB_ASSERT_NOW(a_count_cap, 1'b1, count <= cap_eff, "fill count above capacity")
  `BRRB_ASSERT_NOW(a_ptr_cap, 1'b1, (CntW'(head) < cap_eff) && (CntW'(tail) < cap_eff),
                   "pointer outside used ring")
  `BRRB_ASSERT_NOW(a_shift_range, cmd.shift_wr, CntW'(k) < count, "shift beyond fill")

endmodule
`default_nettype wire

@@ rtl/byte_ring_buffer_with_random_removal_core.sv @@
// top level of the byte ring buffer with removal from any position
// depends on brrb_pkg, brrb_ctrl and brrb_dp
//
// Usage: drive kind, push_byte, position and skip_count with start high; the
// item is taken at a clock edge where busy is low. kind selects push, peek,
// poll (read and remove) or forward (discard from head). Exactly one result
// follows per item: done is high for one cycle with status, read_byte,
// fill_count and free_count valid; there is no way to hold it off, so the
// receiver must sample it in that cycle.
// done follows the accepting edge by way of states EXEC and REPLY for push
// and forward and for failed peek or poll, and EXEC, READ_WAIT and REPLY for
// peek and poll, plus one SHIFT_RD and one SHIFT_WR state per byte moved when
// poll removes from the middle (fill before the poll minus position minus 1
// bytes), since each moved byte takes one read and one write on the single
// ram port pair. busy drops the cycle after done.
// The capacity register is written over cap_valid/cap_ready while idle; a
// write also empties the queue. Reset empties the queue and sets the
// capacity to 128; stored bytes are not cleared.
`default_nettype none
module byte_ring_buffer_with_random_removal_core
  import brrb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [BYTE_W-1:0] push_byte,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [CNT_W-1:0]  skip_count,
  output logic                   done,
  output logic                   status,
  output logic      [BYTE_W-1:0] read_byte,
  output logic      [CNT_W-1:0]  fill_count,
  output logic      [CNT_W-1:0]  free_count,
  input  wire logic              cap_valid,
  output logic                   cap_ready,
  input  wire logic [CNT_W-1:0]  cap_data
);

  cmd_t cmd;
  sts_t sts;

  brrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cap_valid(cap_valid),
    .sts      (sts),
    .busy     (busy),
    .done     (done),
    .cap_ready(cap_ready),
    .cmd      (cmd)
  );

  brrb_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .kind      (kind),
    .push_byte (push_byte),
    .position  (position),
    .skip_count(skip_count),
    .cap_data  (cap_data),
    .sts       (sts),
    .status    (status),
    .read_byte (read_byte),
    .fill_count(fill_count),
    .free_count(free_count)
  );

endmodule
`default_nettype wire

@@ tb/sv/brrb_queue_checker.sv @@
// result checker for the byte ring buffer core: predicts each accepted item
// from its own copy of the queue and compares every done strobe in order
// depends on brrb_pkg
module brrb_queue_checker
  import brrb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [KIND_W-1:0] kind,
  input  logic [BYTE_W-1:0] push_byte,
  input  logic [POS_W-1:0]  position,
  input  logic [CNT_W-1:0]  skip_count,
  input  logic              done,
  input  logic              status,
  input  logic [BYTE_W-1:0] read_byte,
  input  logic [CNT_W-1:0]  fill_count,
  input  logic [CNT_W-1:0]  free_count,
  input  logic              cap_valid,
  input  logic              cap_ready,
  input  logic [CNT_W-1:0]  cap_data,
  output int                fails,
  output int                pending,
  output int                fill_now
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              st;
    logic [BYTE_W-1:0] rb;
    logic [CNT_W-1:0]  fc;
    logic [CNT_W-1:0]  frc;
  } reply_t;

  logic [BYTE_W-1:0] ring [DEPTH_DEFAULT];
  logic [CNT_W-1:0]  cap_reg;
  int                head;
  int                tail;
  int                fill;
  reply_t            replies_due[$];
  reply_t            want;
  reply_t            got;

  function automatic int usable_cap();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH_DEFAULT) return DEPTH_DEFAULT;
    return cap_reg;
  endfunction

  task automatic apply_op(input kind_t op, input logic [BYTE_W-1:0] pb, input int pos,
                          input int skip, output reply_t r);
    int cap;
    int j;
    cap = usable_cap();
    r.st = 1'b0;
    r.rb = '0;
    case (op)
      KIND_PUSH: begin
        if (fill < cap) begin
          ring[tail % DEPTH_DEFAULT] = pb;
          tail = (tail + 1) % cap;
          fill++;
        end else begin
          r.st = 1'b1;
        end
      end
      KIND_PEEK, KIND_POLL: begin
        if (pos < fill) begin
          r.rb = ring[(head + pos) % cap];
          if (op == KIND_POLL) begin
            if (pos == 0) begin
              head = (head + 1) % cap;
            end else begin
              // close the gap toward the head, wrapping inside the used ring
              for (j = pos; j + 1 < fill; j++) begin
                ring[(head + j) % cap] = ring[(head + j + 1) % cap];
              end
              tail = (tail + cap - 1) % cap;
            end
            fill--;
          end
        end else begin
          r.st = 1'b1;
        end
      end
      default: begin
        if (skip <= fill) begin
          head = (head + skip) % cap;
          fill -= skip;
        end else begin
          r.st = 1'b1;
        end
      end
    endcase
    r.fc = fill[CNT_W-1:0];
    r.frc = CNT_W'(cap - fill);
  endtask

  initial begin
    fails = 0;
    pending = 0;
    fill_now = 0;
    cap_reg = CAP_RESET;
    head = 0;
    tail = 0;
    fill = 0;
    for (int i = 0; i < DEPTH_DEFAULT; i++) ring[i] = '0;
  end

  always @(posedge clk) begin
    if (rst) begin
      head = 0;
      tail = 0;
      fill = 0;
      cap_reg = CAP_RESET;
      replies_due.delete();
    end else begin
      if (done) begin
        got.st = status;
        got.rb = read_byte;
        got.fc = fill_count;
        got.frc = free_count;
        if (replies_due.size() == 0) begin
          $error("result with no item outstanding");
          fails++;
        end else begin
          want = replies_due.pop_front();
          if (got.st !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, got.st);
            fails++;
          end
          if (got.rb !== want.rb) begin
            $error("read_byte: expected %0d, got %0d", want.rb, got.rb);
            fails++;
          end
          if (got.fc !== want.fc) begin
            $error("fill_count: expected %0d, got %0d", want.fc, got.fc);
            fails++;
          end
          if (got.frc !== want.frc) begin
            $error("free_count: expected %0d, got %0d", want.frc, got.frc);
            fails++;
          end
        end
      end
      if (cap_valid && cap_ready) begin
        // a capacity write empties the queue
        cap_reg = cap_data;
        head = 0;
        tail = 0;
        fill = 0;
      end
      if (start && !busy) begin
        apply_op(kind_t'(kind), push_byte, position, skip_count, want);
        replies_due.push_back(want);
      end
    end
    pending = replies_due.size();
    fill_now = fill;
  end

endmodule

@@ tb/sv/tb_byte_ring_buffer_with_random_removal_core.sv @@
// testbench top for the byte ring buffer core: directed and random item
// streams over several capacity settings and sender idle patterns
// depends on brrb_pkg, the core and brrb_queue_checker
module tb_byte_ring_buffer_with_random_removal_core
  import brrb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 1000000;
  localparam int NPH = 9;
  localparam logic [CNT_W-1:0] PH_CAP [NPH] =
    '{8'd0, 8'd1, 8'd2, 8'd85, 8'd170, 8'd7, 8'd255, 8'd128, 8'd3};
  localparam int PH_ITEMS [NPH] = '{40, 40, 60, 70, 60, 70, 180, 60, 50};
  localparam int PH_PUSH [NPH] = '{50, 50, 50, 55, 55, 50, 90, 60, 50};

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] push_byte;
  logic [POS_W-1:0]  position;
  logic [CNT_W-1:0]  skip_count;
  logic              done;
  logic              status;
  logic [BYTE_W-1:0] read_byte;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  free_count;
  logic              cap_valid;
  logic              cap_ready;
  logic [CNT_W-1:0]  cap_data;
  int                fails;
  int                pending;
  int                fill_now;
  int                cycles;

  byte_ring_buffer_with_random_removal_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .push_byte(push_byte), .position(position), .skip_count(skip_count),
    .done(done), .status(status), .read_byte(read_byte), .fill_count(fill_count),
    .free_count(free_count), .cap_valid(cap_valid), .cap_ready(cap_ready),
    .cap_data(cap_data)
  );

  brrb_queue_checker mon (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .push_byte(push_byte), .position(position), .skip_count(skip_count),
    .done(done), .status(status), .read_byte(read_byte), .fill_count(fill_count),
    .free_count(free_count), .cap_valid(cap_valid), .cap_ready(cap_ready),
    .cap_data(cap_data), .fails(fails), .pending(pending), .fill_now(fill_now)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue(input kind_t op, input int pb, input int pos, input int skip);
    kind = op;
    push_byte = BYTE_W'(pb);
    position = POS_W'(pos);
    skip_count = CNT_W'(skip);
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic write_cap(input logic [CNT_W-1:0] v);
    drain();
    cap_data = v;
    cap_valid = 1'b1;
    do @(posedge clk); while (!cap_ready);
    @(negedge clk);
    cap_valid = 1'b0;
  endtask

  task automatic random_item(input int push_pct);
    kind_t op;
    int    r;
    int    pos;
    int    skip;
    r = $urandom_range(99);
    if (r < push_pct) begin
      op = KIND_PUSH;
    end else begin
      r = $urandom_range(99);
      op = (r < 35) ? KIND_PEEK : (r < 80) ? KIND_POLL : KIND_FWD;
    end
    r = $urandom_range(99);
    if (r < 75) pos = (fill_now == 0) ? 0 : $urandom_range(fill_now - 1);
    else if (r < 85) pos = (fill_now > 127) ? 127 : fill_now;
    else pos = $urandom_range(127);
    r = $urandom_range(99);
    if (r < 55) skip = $urandom_range((fill_now > 4) ? 4 : fill_now);
    else if (r < 70) skip = $urandom_range(fill_now);
    else if (r < 80) skip = fill_now;
    else if (r < 90) skip = fill_now + 1;
    else skip = $urandom_range(255);
    issue(op, $urandom_range(255), pos, skip);
  endtask

  initial begin
    logic [CNT_W-1:0] cap;
    int               idle_pct;
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_PUSH;
    push_byte = '0;
    position = '0;
    skip_count = '0;
    cap_valid = 1'b0;
    cap_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset capacity, then a tiny ring for full and wrap cases
    issue(KIND_PUSH, 8'hFF, 0, 0);
    issue(KIND_PEEK, 0, 0, 0);
    issue(KIND_PEEK, 0, 127, 0);
    issue(KIND_FWD, 0, 0, 1);
    write_cap(8'd3);
    issue(KIND_PUSH, 8'h00, 0, 0);
    issue(KIND_PUSH, 8'hFF, 0, 0);
    issue(KIND_PUSH, 8'h5A, 0, 0);
    issue(KIND_PUSH, 8'h11, 0, 0);
    issue(KIND_PEEK, 0, 2, 0);
    issue(KIND_PEEK, 0, 3, 0);
    issue(KIND_POLL, 0, 1, 0);
    issue(KIND_PUSH, 8'h80, 0, 0);
    issue(KIND_POLL, 0, 0, 0);
    issue(KIND_PEEK, 0, 1, 0);
    issue(KIND_POLL, 0, 1, 0);
    issue(KIND_FWD, 0, 0, 255);
    issue(KIND_FWD, 0, 0, 0);
    issue(KIND_FWD, 0, 0, 1);
    issue(KIND_POLL, 0, 0, 0);
    issue(KIND_PEEK, 0, 0, 0);

    for (int ph = 0; ph < NPH; ph++) begin
      cap = (ph == NPH - 1) ? CNT_W'($urandom_range(1, 128)) : PH_CAP[ph];
      write_cap(cap);
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 50 : 25;
      for (int i = 0; i < PH_ITEMS[ph]; i++) begin
        if (i == PH_ITEMS[ph] / 2 || $urandom_range(99) < 2) begin
          drain();
        end else if ($urandom_range(99) < idle_pct) begin
          start = 1'b0;
          repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        random_item(PH_PUSH[ph]);
      end
    end

    start = 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/brrb_pkg.sv
rtl/brrb_ram.sv
rtl/brrb_ctrl.sv
rtl/brrb_dp.sv
rtl/byte_ring_buffer_with_random_removal_core.sv
tb/sv/brrb_queue_checker.sv
tb/sv/tb_byte_ring_buffer_with_random_removal_core.sv
